>>> design/bam_pkg.sv
// ----------------------------------------------------------------------------
// bam_pkg: shared types and constants for the BCD add/multiply unit
// Digit count, column widths, payload structs and the nibble check.
// ----------------------------------------------------------------------------
package bam_pkg;

   localparam int DIGITS  = 16;                       // decimal digits per operand
   localparam int DATA_W  = 64;                       // payload field width
   localparam int RES_W   = DIGITS * 4;               // bits that hold real digits
   localparam int COL_MAX = DIGITS * 81;              // largest column sum in a product
   localparam int COL_W   = $clog2(COL_MAX + 1);
   localparam int T_W     = COL_W + 1;                // column plus incoming carry
   localparam int CARRY_W = T_W - 3;                  // t / 10 fits here
   localparam int CNT_W   = $clog2(DIGITS + 1);

   // x / 10 == (x * RECIP) >> RECIP_SHIFT for every x below 2**16
   localparam int RECIP_W     = 16;
   localparam logic [RECIP_W-1:0] RECIP = 16'hCCCD;
   localparam int RECIP_SHIFT = 19;
   localparam int RADIX       = 10;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_MUL = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
   } bam_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_bcd;
      logic              overflow;
      logic              bad_digit;
   } bam_rsp_type;

   // control from the sequencer to the column generator
   typedef struct packed {
      logic load;
      logic step;
   } bam_ctl_type;

   // one finished column per transfer, plus the status of the columns left over
   typedef struct packed {
      logic             valid;
      logic [COL_W-1:0] col;
      logic             high_nz;
   } bam_col_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } bam_state_type;

   function automatic logic bcd_bad(input logic [DATA_W-1:0] x);
      logic bad;
      bad = 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
         if (x[4*i +: 4] > 4'd9) bad = 1'b1;
      end
      return bad;
   endfunction

endpackage

>>> design/bcd_add_multiply_unit_top.sv
// ----------------------------------------------------------------------------
// bcd_add_multiply_unit_top: packed BCD add / multiply unit
// rsp_valid rises after the digit loop (ST_RUN) and the hold state (ST_HOLD).
// A new request is taken only while idle or as the held result moves out;
//   the column generator takes one digit (one multiplier digit) per cycle.
// Reset (synchronous, active high) clears the sequencer and the output valid;
//   no clearing pass, the unit is ready once reset drops.
// ----------------------------------------------------------------------------
module bcd_add_multiply_unit_top import bam_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bam_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bam_rsp_type rsp_data
);

   // Flow: a request transfer loads the column generator and clears the
   // normalizer. The generator then emits DIGITS raw columns, one a
   // cycle; the normalizer folds in each in the cycle after. Overflow is a
   // carry left after the top kept digit, or any nonzero column above it (all
   // columns are nonnegative, so the discarded part is zero only if all are zero).

   bam_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              bad_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   bam_rsp_type       rsp_ff, rsp_in;

   bam_ctl_type       ctl;
   bam_col_type       col;
   logic [RES_W-1:0]  norm_res;
   logic              carry_nz;

   logic              out_free;
   logic              load_out;
   logic              req_xfer;
   logic              last_col;

   bam_colgen u_colgen (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .req   (req_data),
      .col   (col)
   );

   bam_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .clear    (ctl.load),
      .col      (col),
      .res      (norm_res),
      .carry_nz (carry_nz)
   );

   // output slot frees up when empty or when its transfer happens now
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = (state_ff == ST_HOLD) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || load_out;
   assign req_xfer  = req_valid && req_ready;
   assign last_col  = (cnt_ff == CNT_W'(DIGITS));

   assign ctl.load = req_xfer;
   assign ctl.step = (state_ff == ST_RUN) && !last_col;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            // advance one column per cycle; no step at the last count, so the normalizer drains
            cnt_in = cnt_ff + CNT_W'(1);
            if (last_col) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            // hold the finished result until the output slot is free
            if (load_out) begin
               state_in = req_xfer ? ST_RUN : ST_IDLE;
               cnt_in   = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      if (bad_ff) begin
         rsp_in.result_bcd = '0;
         rsp_in.overflow   = 1'b0;
         rsp_in.bad_digit  = 1'b1;
      end else begin
         rsp_in.result_bcd = DATA_W'(norm_res);
         rsp_in.overflow   = carry_nz || col.high_nz;
         rsp_in.bad_digit  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         bad_ff <= bcd_bad(req_data.operand_a) || bcd_bad(req_data.operand_b);
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a request transfer always starts the digit loop
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_RUN))
      else $error("request transfer did not start the digit loop");

   // a new result only appears out of the hold state
   a_result_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_HOLD))
      else $error("result presented without a finished computation");

   // the column stream is drained before the result is taken
   a_cols_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> !col.valid)
      else $error("column still in flight while result is held");

   // a bad nibble forces a zero result without overflow
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_digit) |->
         (rsp_data.result_bcd == '0) && !rsp_data.overflow)
      else $error("bad digit result not cleared");

endmodule

>>> design/bam_colgen.sv
// ----------------------------------------------------------------------------
// bam_colgen: decimal column generator
// Emits one raw (unnormalized) decimal column per step. Add mode sums one
// digit pair per step; multiply mode adds A times one multiplier digit into
// a sliding window of column sums and retires its lowest column.
// ----------------------------------------------------------------------------
module bam_colgen import bam_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bam_ctl_type ctl,
   input  bam_req_type req,
   output bam_col_type col
);

   logic [RES_W-1:0] a_ff, b_ff;
   logic             mul_ff;
   logic [COL_W-1:0] win_ff [DIGITS];
   logic [COL_W-1:0] win_in [DIGITS];
   logic [COL_W-1:0] sum_v  [DIGITS];
   logic [COL_W-1:0] col_ff, col_in;
   logic             valid_ff;
   logic             high_nz;

   always_comb begin
      logic [7:0] prod;
      prod = '0;
      for (int i = 0; i < DIGITS; i++) begin
         prod     = 8'(a_ff[4*i +: 4]) * 8'(b_ff[3:0]);
         sum_v[i] = win_ff[i] + COL_W'(prod);
      end
      for (int i = 0; i < DIGITS - 1; i++) begin
         win_in[i] = sum_v[i+1];
      end
      win_in[DIGITS-1] = '0;
      col_in = mul_ff ? sum_v[0] : COL_W'(a_ff[3:0]) + COL_W'(b_ff[3:0]);
   end

   // window holds the high columns once all multiplier digits are in;
   // in add mode it carries no meaning, so drop it there
   always_comb begin
      high_nz = 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
         if (mul_ff && (win_ff[i] != '0)) high_nz = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.step;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         a_ff   <= req.operand_a[RES_W-1:0];
         b_ff   <= req.operand_b[RES_W-1:0];
         mul_ff <= (req.req_type == OP_MUL);
         for (int i = 0; i < DIGITS; i++) win_ff[i] <= '0;
      end else if (ctl.step) begin
         // multiplicand stays put in multiply mode
         a_ff   <= mul_ff ? a_ff : (a_ff >> 4);
         b_ff   <= b_ff >> 4;
         win_ff <= win_in;
         col_ff <= col_in;
      end
   end

   assign col.valid   = valid_ff;
   assign col.col     = col_ff;
   assign col.high_nz = high_nz;

endmodule

>>> design/bam_norm.sv
// ----------------------------------------------------------------------------
// bam_norm: decimal carry normalizer
// Adds the running carry to each raw column, keeps the low decimal digit in
// a result shift register and passes the quotient on as the next carry.
// ----------------------------------------------------------------------------
module bam_norm import bam_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  bam_col_type      col,
   output logic [RES_W-1:0] res,
   output logic             carry_nz
);

   logic [CARRY_W-1:0]     carry_ff, carry_in;
   logic [RES_W-1:0]       res_ff, res_in;
   logic [T_W-1:0]         t_val, rem;
   logic [T_W+RECIP_W-1:0] recip_prod;
   logic [RES_W+3:0]       shifted;
   logic [3:0]             digit;

   always_comb begin
      t_val      = T_W'(col.col) + T_W'(carry_ff);
      recip_prod = (T_W+RECIP_W)'(t_val) * (T_W+RECIP_W)'(RECIP);
      carry_in   = CARRY_W'(recip_prod >> RECIP_SHIFT);
      rem        = t_val - T_W'(carry_in) * T_W'(RADIX);
      digit      = rem[3:0];
      // digits arrive low first: insert at the top, move the rest down
      shifted    = {digit, res_ff} >> 4;
      res_in     = shifted[RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else if (clear) begin
         carry_ff <= '0;
      end else if (col.valid) begin
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (col.valid) begin
         res_ff <= res_in;
      end
   end

   assign res      = res_ff;
   assign carry_nz = (carry_ff != '0);

endmodule
